FILE: hdl/piecewise_linear_interpolator_top_defines.svh
// Assertion helpers for the piecewise linear interpolator.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pli_pkg.sv
package pli_pkg;

  // Fixed field widths of the interface
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int MIN_POINTS = 2;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd2;

  // Command codes carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SUB,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUM,
    ST_RESULT
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/pli_ram.sv
module pli_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pli_div.sv
`include "piecewise_linear_interpolator_top_defines.svh"

module pli_div #(
  parameter int N_W = 26,
  parameter int D_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [N_W-1:0]      dividend,
  input  logic [D_W-1:0]      divisor,
  output logic [N_W-1:0]      quotient,
  output pli_pkg::div_stat_t  stat
);

  localparam int CW = $clog2(N_W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [D_W-1:0] rem_r;
  logic [N_W-1:0] quo_r;
  logic [D_W-1:0] den_r;

  logic [D_W:0] rem_sh;
  logic [D_W:0] rem_diff;
  logic         fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {rem_r, quo_r[N_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    fits     = (rem_sh >= {1'b0, den_r});
  end

  // Control: busy while the quotient bits are produced, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Datapath: load operands, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      cnt_r <= CW'(N_W);
    end else if (busy_r) begin
      rem_r <= fits ? rem_diff[D_W-1:0] : rem_sh[D_W-1:0];
      quo_r <= {quo_r[N_W-2:0], fits};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `PLI_ASSERT_SAME(a_start_idle, start, !busy_r, "divider started while busy")
  `PLI_ASSERT_NEXT(a_start_busy, start, busy_r, "divider did not go busy after start")
  `PLI_ASSERT_NEXT(a_done_follows, busy_r && (cnt_r == CW'(1)), done_r && !busy_r,
                   "divider did not finish after its last step")

endmodule

FILE: hdl/piecewise_linear_interpolator_top.sv
// Piecewise linear interpolator: a table of control points (x, y) in unsigned
// fixed point with FRAC_BITS fraction bits, evaluated by linear interpolation.
// Input channel in_*: in_tuser is the command (write point or evaluate).
// A write stores one point and gives no result. An evaluate gives one result
// transaction on out_* (value and found flag). When query_x is 0 or at
// least 1.0 the evaluate reads the first or last point in use and gives its
// y; else the segment search visits table entries in turn (one RAM read and
// one compare each), then setup and multiply, then the bit-serial divider.
// One evaluate is in flight at a time, on the single table read port.
// cfg_* writes point_count and is always ready; write it only while idle.
// Reset (synchronous, rst_n low) returns to idle, empties the output
// register, sets point_count to 2 and makes slots 0 and 1 read as (0, 0) and
// (1.0, 1.0) until written. Other slots read undefined until written.
// When the receiver stalls, the finished result waits in the output
// register; new items are still taken, and a later result waits until it frees.
`include "piecewise_linear_interpolator_top_defines.svh"

module piecewise_linear_interpolator_top #(
  parameter int MAX_POINTS = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic clk,
  input  logic rst_n,

  // in_tdata: point_index, point_x, point_y, query_x (lowest bit up)
  input  logic [((pli_pkg::IDX_W+3*(FRAC_BITS+1)+7)/8)*8-1:0] in_tdata,
  // in_tuser: cmd
  input  logic in_tuser,
  input  logic in_tvalid,
  output logic in_tready,

  // out_tdata: value (lowest bit up)
  output logic [((FRAC_BITS+1+7)/8)*8-1:0] out_tdata,
  // out_tuser: found
  output logic out_tuser,
  output logic out_tvalid,
  input  logic out_tready,

  input  logic [pli_pkg::CNT_W-1:0] cfg_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready
);

  localparam int V     = FRAC_BITS + 1;
  localparam int S     = V + 1;
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int OUT_W = ((V + 7) / 8) * 8;
  localparam int IW    = pli_pkg::IDX_W;
  localparam logic [V-1:0] ONE_FX   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [V-1:0] VAL_MAX  = {V{1'b1}};

  // Input field unpack
  logic [IW-1:0] in_idx;
  logic [V-1:0]  in_px;
  logic [V-1:0]  in_py;
  logic [V-1:0]  in_qx;
  assign in_idx = in_tdata[IW-1:0];
  assign in_px  = in_tdata[IW +: V];
  assign in_py  = in_tdata[IW+V +: V];
  assign in_qx  = in_tdata[IW+2*V +: V];

  pli_pkg::state_t state_r, state_nxt;

  logic [pli_pkg::CNT_W-1:0] point_count_r;
  logic          out_tvalid_r;
  logic [V-1:0]  out_value_r;
  logic          out_found_r;
  logic          wr0_r;
  logic          wr1_r;

  logic [AW-1:0] addr_r;
  logic          bound_r;
  logic [V-1:0]  qx_r;
  logic [V-1:0]  x0_r, y0_r, x1_r, y1_r;
  logic signed [S-1:0]   dx_r, dy_r, den_r;
  logic signed [2*S-1:0] prod_r;
  logic          neg_r;
  logic [V-1:0]  res_val_r;
  logic          res_found_r;

  logic in_acc;
  logic div_start;
  logic out_load;

  // Count clamp and index of the last point in use
  logic [8:0]    cnt_ext;
  logic [8:0]    n_used;
  logic [8:0]    last_ext;
  logic [AW-1:0] last_idx;
  always_comb begin
    cnt_ext = 9'(point_count_r);
    if (cnt_ext < 9'(pli_pkg::MIN_POINTS)) begin
      n_used = 9'(pli_pkg::MIN_POINTS);
    end else if (cnt_ext > 9'(MAX_POINTS)) begin
      n_used = 9'(MAX_POINTS);
    end else begin
      n_used = cnt_ext;
    end
    last_ext = n_used - 9'd1;
    last_idx = last_ext[AW-1:0];
  end

  // Table write decode
  logic [7:0]    idx_ext;
  logic          wr_en;
  logic [AW-1:0] waddr;
  assign idx_ext = 8'(in_idx);
  assign waddr   = idx_ext[AW-1:0];
  assign wr_en   = in_acc && (in_tuser == pli_pkg::CMD_WRITE) &&
                   ({1'b0, idx_ext} < 9'(MAX_POINTS));

  logic [2*V-1:0] ram_rdata;

  pli_ram #(
    .WIDTH (2 * V),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata ({in_py, in_px}),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Overlay reset values on slots 0 and 1 until they are written
  logic [V-1:0] kx, ky;
  always_comb begin
    kx = ram_rdata[V-1:0];
    ky = ram_rdata[2*V-1:V];
    if ((addr_r == '0) && !wr0_r) begin
      kx = '0;
      ky = '0;
    end else if ((addr_r == AW'(1)) && !wr1_r) begin
      kx = ONE_FX;
      ky = ONE_FX;
    end
  end

  logic hit;
  assign hit = (qx_r <= kx);

  // Divider operands are magnitudes; sign is restored afterwards
  logic [2*S-1:0] prod_abs;
  logic [S-1:0]   den_abs;
  logic [2*V-1:0] quotient;
  pli_pkg::div_stat_t div_stat;
  always_comb begin
    prod_abs = prod_r[2*S-1] ? (2*S)'(-prod_r) : (2*S)'(prod_r);
    den_abs  = den_r[S-1] ? S'(-den_r) : S'(den_r);
  end

  pli_div #(
    .N_W (2 * V),
    .D_W (V)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_abs[2*V-1:0]),
    .divisor  (den_abs[V-1:0]),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Add the signed quotient to y0 and saturate
  logic signed [2*V+1:0] q_signed;
  logic signed [2*V+1:0] sum;
  logic [V-1:0]          sum_sat;
  always_comb begin
    q_signed = neg_r ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    sum      = q_signed + $signed((2*V+2)'(y0_r));
    if (sum < 0) begin
      sum_sat = '0;
    end else if (sum > $signed((2*V+2)'(VAL_MAX))) begin
      sum_sat = VAL_MAX;
    end else begin
      sum_sat = sum[V-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pli_pkg::ST_IDLE: begin
        if (in_tvalid && (in_tuser == pli_pkg::CMD_EVAL)) begin
          state_nxt = pli_pkg::ST_READ;
        end
      end
      pli_pkg::ST_READ:  state_nxt = pli_pkg::ST_CHECK;
      pli_pkg::ST_CHECK: begin
        if (bound_r) begin
          state_nxt = pli_pkg::ST_RESULT;
        end else if (addr_r == '0) begin
          state_nxt = pli_pkg::ST_READ;
        end else if (hit) begin
          state_nxt = pli_pkg::ST_SUB;
        end else if (addr_r == last_idx) begin
          state_nxt = pli_pkg::ST_RESULT;
        end else begin
          state_nxt = pli_pkg::ST_READ;
        end
      end
      pli_pkg::ST_SUB: state_nxt = pli_pkg::ST_MUL;
      pli_pkg::ST_MUL: begin
        state_nxt = (den_r == '0) ? pli_pkg::ST_RESULT : pli_pkg::ST_DIV_GO;
      end
      pli_pkg::ST_DIV_GO: state_nxt = pli_pkg::ST_DIV_WAIT;
      pli_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = pli_pkg::ST_SUM;
        end
      end
      pli_pkg::ST_SUM: state_nxt = pli_pkg::ST_RESULT;
      pli_pkg::ST_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = pli_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pli_pkg::ST_IDLE;
    endcase
  end

  // State decoded outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      pli_pkg::ST_IDLE:   in_tready = 1'b1;
      pli_pkg::ST_DIV_GO: div_start = 1'b1;
      pli_pkg::ST_RESULT: out_load  = !out_tvalid_r || out_tready;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign in_acc = in_tvalid && in_tready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pli_pkg::ST_IDLE;
      out_tvalid_r  <= 1'b0;
      wr0_r         <= 1'b0;
      wr1_r         <= 1'b0;
      point_count_r <= pli_pkg::CNT_RESET;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (wr_en && (waddr == '0)) begin
        wr0_r <= 1'b1;
      end
      if (wr_en && (waddr == AW'(1))) begin
        wr1_r <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        point_count_r <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      pli_pkg::ST_IDLE: begin
        qx_r <= in_qx;
        if (in_qx == '0) begin
          addr_r  <= '0;
          bound_r <= 1'b1;
        end else if (in_qx[V-1]) begin
          addr_r  <= last_idx;
          bound_r <= 1'b1;
        end else begin
          addr_r  <= '0;
          bound_r <= 1'b0;
        end
      end
      pli_pkg::ST_CHECK: begin
        if (bound_r) begin
          res_val_r   <= ky;
          res_found_r <= 1'b1;
        end else if (addr_r == '0) begin
          x0_r   <= kx;
          y0_r   <= ky;
          addr_r <= addr_r + AW'(1);
        end else if (hit) begin
          x1_r <= kx;
          y1_r <= ky;
        end else begin
          x0_r <= kx;
          y0_r <= ky;
          if (addr_r == last_idx) begin
            res_val_r   <= '0;
            res_found_r <= 1'b0;
          end else begin
            addr_r <= addr_r + AW'(1);
          end
        end
      end
      pli_pkg::ST_SUB: begin
        dx_r  <= $signed({1'b0, qx_r}) - $signed({1'b0, x0_r});
        dy_r  <= $signed({1'b0, y1_r}) - $signed({1'b0, y0_r});
        den_r <= $signed({1'b0, x1_r}) - $signed({1'b0, x0_r});
      end
      pli_pkg::ST_MUL: begin
        prod_r <= dx_r * dy_r;
        if (den_r == '0) begin
          res_val_r   <= y0_r;
          res_found_r <= 1'b1;
        end
      end
      pli_pkg::ST_DIV_GO: begin
        neg_r <= prod_r[2*S-1] ^ den_r[S-1];
      end
      pli_pkg::ST_SUM: begin
        res_val_r   <= sum_sat;
        res_found_r <= 1'b1;
      end
      pli_pkg::ST_RESULT: begin
        if (out_load) begin
          out_value_r <= res_val_r;
          out_found_r <= res_found_r;
        end
      end
      default: begin
        neg_r <= neg_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_value_r);
  assign out_tuser  = out_found_r;
  assign cfg_ready  = 1'b1;

  `PLI_ASSERT_SAME(a_search_bound, state_r == pli_pkg::ST_CHECK, addr_r <= last_idx,
                   "table read beyond the last point in use")
  `PLI_ASSERT_SAME(a_miss_zero, out_tvalid_r && !out_found_r, out_value_r == '0,
                   "result without a match carries a nonzero value")
  `PLI_ASSERT_NEXT(a_eval_busy,
                   in_tvalid && in_tready && (in_tuser == pli_pkg::CMD_EVAL),
                   !in_tready, "new transaction taken during an evaluate")
  `PLI_ASSERT_NEXT(a_result_load, out_load, out_tvalid_r,
                   "finished result did not reach the output register")
  `PLI_ASSERT_SAME(a_div_owned, div_stat.busy, state_r == pli_pkg::ST_DIV_WAIT,
                   "divider busy outside the wait state")

endmodule
